[hw/rtl/sws_pkg.sv]
// Shared types and constants of the sliding-window spread block.
`timescale 1ns / 1ps
`default_nettype none
package sws_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 11;

  // register index of window_size
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // classification of one word, made by the front end
  typedef struct packed {
    logic last;    // final sample of the sequence
    logic evict;   // window already full: oldest slot leaves
    logic active;  // window full after this sample: spread counts
  } item_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/sws_front.sv]
// Front end: accepts words, tracks ring slot and fill, queues classified words.
`timescale 1ns / 1ps
`default_nettype none
module sws_front #(
  parameter int MAX_WINDOW = 1024
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              clear,
  input  wire [$clog2(MAX_WINDOW):0]       win,
  input  wire                              in_push,
  output logic                             in_full,
  input  wire [sws_pkg::SAMPLE_W-1:0]      in_sample,
  input  wire                              in_last,
  output logic                             item_valid,
  input  wire                              item_ready,
  output sws_pkg::item_ctl_t               item_ctl,
  output logic [sws_pkg::SAMPLE_W-1:0]     item_sample,
  output logic [$clog2(MAX_WINDOW)-1:0]    item_slot,
  output logic [$clog2(MAX_WINDOW)-1:0]    item_old
);
  import sws_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);

  function automatic logic [AW-1:0] wrap(input logic [AW+1:0] s);
    if (s >= (AW+2)'(MAX_WINDOW)) return AW'(s - (AW+2)'(MAX_WINDOW));
    else return AW'(s);
  endfunction

  logic [AW:0]   fill_r, fill_nxt, fill_inc;
  logic [AW-1:0] slot_r, slot_nxt;

  // two-entry queue towards the back end
  item_ctl_t              q_ctl_r    [2];
  logic [SAMPLE_W-1:0]    q_sample_r [2];
  logic [AW-1:0]          q_slot_r   [2];
  logic [AW-1:0]          q_old_r    [2];
  logic                   wp_r, rp_r;
  logic [1:0]             cnt_r;

  logic      push_ok, pop_ok;
  item_ctl_t ctl_new;
  logic [AW-1:0] old_new;

  assign in_full    = (cnt_r == 2'd2);
  assign push_ok    = in_push && !in_full;
  assign item_valid = (cnt_r != 2'd0);
  assign pop_ok     = item_valid && item_ready;

  assign item_ctl    = q_ctl_r[rp_r];
  assign item_sample = q_sample_r[rp_r];
  assign item_slot   = q_slot_r[rp_r];
  assign item_old    = q_old_r[rp_r];

  always_comb begin
    fill_inc       = (fill_r == (AW+1)'(MAX_WINDOW)) ? fill_r : fill_r + 1'b1;
    ctl_new.last   = in_last;
    ctl_new.evict  = (fill_r >= win);
    ctl_new.active = (fill_inc >= win);
    old_new  = wrap({2'b00, slot_r} + (AW+2)'(MAX_WINDOW) - {1'b0, win});
    fill_nxt = fill_r;
    slot_nxt = slot_r;
    if (clear) begin
      fill_nxt = '0;
    end else if (push_ok) begin
      fill_nxt = in_last ? '0 : fill_inc;
      slot_nxt = wrap({2'b00, slot_r} + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      slot_r <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      slot_r <= slot_nxt;
      if (push_ok) wp_r <= !wp_r;
      if (pop_ok)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
    if (push_ok) begin
      q_ctl_r[wp_r]    <= ctl_new;
      q_sample_r[wp_r] <= in_sample;
      q_slot_r[wp_r]   <= slot_r;
      q_old_r[wp_r]    <= old_new;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sws_back.sv]
// Back end: max and min monotonic queues in memory, spread tracking.
`timescale 1ns / 1ps
`default_nettype none
module sws_back #(
  parameter int MAX_WINDOW = 1024
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              clear,
  input  wire                              item_valid,
  output logic                             item_ready,
  input  sws_pkg::item_ctl_t               item_ctl,
  input  wire [sws_pkg::SAMPLE_W-1:0]      item_sample,
  input  wire [$clog2(MAX_WINDOW)-1:0]     item_slot,
  input  wire [$clog2(MAX_WINDOW)-1:0]     item_old,
  input  wire                              res_busy,
  output logic                             res_valid,
  output logic [sws_pkg::SAMPLE_W-1:0]     res_spread
);
  import sws_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int EW = AW + SAMPLE_W;

  function automatic logic [AW-1:0] wrap(input logic [AW+1:0] s);
    if (s >= (AW+2)'(MAX_WINDOW)) return AW'(s - (AW+2)'(MAX_WINDOW));
    else return AW'(s);
  endfunction

  typedef enum logic [2:0] {S_IDLE, S_TAIL, S_CMP, S_PUSH, S_HRD, S_HCAP} state_t;

  // queue 0 keeps maxima, queue 1 minima; entry is {slot, value}
  logic [EW-1:0] qmem [2][MAX_WINDOW];
  logic [EW-1:0] rd_q [2];

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r [2], head_nxt [2];
  logic [AW:0]         cnt_r  [2], cnt_nxt  [2];
  logic [1:0]          act_r, act_nxt;
  logic [AW-1:0]       hslot_r [2], hslot_nxt [2];
  logic [SAMPLE_W-1:0] best_r, best_nxt;
  logic [SAMPLE_W-1:0] x_r, x_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  item_ctl_t           ctl_r, ctl_nxt;

  logic [AW-1:0] raddr [2], waddr [2];
  logic [1:0]    re, we;

  always_comb begin
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] d;
    logic [SAMPLE_W-1:0] cand;
    logic                pop;
    state_nxt  = state_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    act_nxt    = act_r;
    hslot_nxt  = hslot_r;
    best_nxt   = best_r;
    x_nxt      = x_r;
    slot_nxt   = slot_r;
    ctl_nxt    = ctl_r;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    re         = '0;
    we         = '0;
    v          = '0;
    pop        = 1'b0;
    d          = rd_q[0][SAMPLE_W-1:0] - rd_q[1][SAMPLE_W-1:0];
    cand       = (ctl_r.active && d > best_r) ? d : best_r;
    res_spread = cand;
    for (int q = 0; q < 2; q++) begin
      raddr[q] = (state_r == S_TAIL)
               ? wrap({2'b00, head_r[q]} + {1'b0, cnt_r[q]} - 1'b1) : head_r[q];
      waddr[q] = wrap({2'b00, head_r[q]} + {1'b0, cnt_r[q]});
    end
    unique case (state_r)
      S_IDLE: begin
        item_ready = 1'b1;
        if (clear) begin
          for (int q = 0; q < 2; q++) begin
            head_nxt[q] = '0;
            cnt_nxt[q]  = '0;
          end
          best_nxt = '0;
        end else if (item_valid) begin
          x_nxt    = item_sample;
          slot_nxt = item_slot;
          ctl_nxt  = item_ctl;
          for (int q = 0; q < 2; q++) begin
            if (item_ctl.evict && cnt_r[q] != '0 && hslot_r[q] == item_old) begin
              head_nxt[q] = wrap({2'b00, head_r[q]} + 1'b1);
              cnt_nxt[q]  = cnt_r[q] - 1'b1;
            end
            act_nxt[q] = (cnt_nxt[q] != '0);
          end
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        re        = act_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        for (int q = 0; q < 2; q++) begin
          v   = rd_q[q][SAMPLE_W-1:0];
          pop = (q == 0) ? (v <= x_r) : (v >= x_r);
          if (act_r[q]) begin
            if (pop) begin
              cnt_nxt[q] = cnt_r[q] - 1'b1;
              act_nxt[q] = (cnt_r[q] != (AW+1)'(1));
            end else begin
              act_nxt[q] = 1'b0;
            end
          end
        end
        state_nxt = (act_nxt != '0) ? S_TAIL : S_PUSH;
      end
      S_PUSH: begin
        we = '1;
        for (int q = 0; q < 2; q++) cnt_nxt[q] = cnt_r[q] + 1'b1;
        state_nxt = S_HRD;
      end
      S_HRD: begin
        re        = '1;
        state_nxt = S_HCAP;
      end
      S_HCAP: begin
        for (int q = 0; q < 2; q++) hslot_nxt[q] = rd_q[q][EW-1:SAMPLE_W];
        if (!ctl_r.last) begin
          best_nxt  = cand;
          state_nxt = S_IDLE;
        end else if (!res_busy) begin
          res_valid = 1'b1;
          best_nxt  = '0;
          for (int q = 0; q < 2; q++) begin
            head_nxt[q] = '0;
            cnt_nxt[q]  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int q = 0; q < 2; q++) begin
        head_r[q] <= '0;
        cnt_r[q]  <= '0;
      end
      act_r  <= '0;
      best_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      best_r  <= best_nxt;
    end
    hslot_r <= hslot_nxt;
    x_r     <= x_nxt;
    slot_r  <= slot_nxt;
    ctl_r   <= ctl_nxt;
  end

  always_ff @(posedge clk) begin
    for (int q = 0; q < 2; q++) begin
      if (we[q]) qmem[q][waddr[q]] <= {slot_r, x_r};
      if (re[q]) rd_q[q] <= qmem[q][raddr[q]];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sliding_window_max_spread.sv]
// Top level: config register, front end, back end and result register.
`timescale 1ns / 1ps
`default_nettype none
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+------------------------------
// input    | in_sample, in_last                      | in_push & !in_full
// result   | out_spread                              | out_pop & !out_empty
// config   | cfg_paddr, cfg_pwdata, cfg_prdata       | psel & penable & pwrite
//
// Each queue memory has a single read port; in the back end a word passes S_IDLE,
// S_TAIL/S_CMP per pop round (both queues pop in parallel), S_PUSH, S_HRD, S_HCAP.
// The two-word front queue lets input run up to two words ahead of the back end.
// Reset clears pointers, fill and best spread; no memory clearing pass is needed.
// A final word stalls the back end only while the previous result waits unpopped.
module sliding_window_max_spread #(
  parameter int MAX_WINDOW = 1024
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_push,
  output logic                         in_full,
  input  wire [sws_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire                          in_last,
  output logic                         out_empty,
  input  wire                          out_pop,
  output logic [sws_pkg::SAMPLE_W-1:0] out_spread,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [2:0]                    cfg_paddr,
  input  wire [31:0]                   cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import sws_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int WW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  logic [CFG_W-1:0] window_size_r;
  logic             cfg_wr, clear;
  logic [WW-1:0]    ws_ext;
  logic [AW:0]      win;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign clear      = cfg_wr && (cfg_paddr[2] == REG_WINDOW_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_SIZE)
                    ? {{(32-CFG_W){1'b0}}, window_size_r} : '0;

  // zero means one; above the ring depth saturates
  always_comb begin
    ws_ext = WW'(window_size_r);
    if (ws_ext == '0)                    win = (AW+1)'(1);
    else if (ws_ext > WW'(MAX_WINDOW))   win = (AW+1)'(MAX_WINDOW);
    else                                 win = ws_ext[AW:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) window_size_r <= CFG_W'(1);
    else if (clear) window_size_r <= cfg_pwdata[CFG_W-1:0];
  end

  logic               item_valid, item_ready;
  item_ctl_t          item_ctl;
  logic [SAMPLE_W-1:0] item_sample;
  logic [AW-1:0]      item_slot, item_old;
  logic               res_valid;
  logic [SAMPLE_W-1:0] res_spread;

  sws_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk, .rst_n, .clear, .win,
    .in_push, .in_full, .in_sample, .in_last,
    .item_valid, .item_ready, .item_ctl, .item_sample, .item_slot, .item_old
  );

  // result word register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_spread_r;

  sws_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk, .rst_n, .clear,
    .item_valid, .item_ready, .item_ctl, .item_sample, .item_slot, .item_old,
    .res_busy(out_valid_r), .res_valid, .res_spread
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) out_spread_r <= res_spread;
  end

  assign out_empty  = !out_valid_r;
  assign out_spread = out_spread_r;

  // back end never emits over a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_valid_r) else $error("result emitted while one waits");

  // a result only appears after the back end emitted one
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_valid)) else $error("result without emission");

endmodule
`default_nettype wire

[tb/sws_spread_checker.sv]
// Checker: watches the input, result and register channels, predicts spreads, compares.
`timescale 1ns / 1ps
`default_nettype none
module sws_spread_checker #(
  parameter int MAX_WINDOW = 1024
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_push,
  input  wire                          in_full,
  input  wire [sws_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire                          in_last,
  input  wire                          out_empty,
  input  wire                          out_pop,
  input  wire [sws_pkg::SAMPLE_W-1:0]  out_spread,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire                          cfg_pready,
  input  wire [2:0]                    cfg_paddr,
  input  wire [31:0]                   cfg_pwdata,
  output int                           fail_count,
  output int                           spreads_pending,
  output int                           spreads_seen
);

  logic [sws_pkg::CFG_W-1:0]    window_reg;
  logic [sws_pkg::SAMPLE_W-1:0] recent[$];    // samples of the current window
  logic [sws_pkg::SAMPLE_W-1:0] best_gap;
  logic [sws_pkg::SAMPLE_W-1:0] spread_q[$];  // spreads still owed by the block
  int                           fails;
  int                           seen;

  function automatic int unsigned span_len();
    if (window_reg == 0) return 1;
    if (window_reg > MAX_WINDOW) return MAX_WINDOW;
    return window_reg;
  endfunction

  // advance the predicted sequence by one word
  task automatic take_sample(input logic [sws_pkg::SAMPLE_W-1:0] s, input logic fin);
    int unsigned                  w;
    logic [sws_pkg::SAMPLE_W-1:0] hi;
    logic [sws_pkg::SAMPLE_W-1:0] lo;
    w = span_len();
    recent.push_back(s);
    if (recent.size() > w) void'(recent.pop_front());
    if (recent.size() == w) begin
      hi = recent[0];
      lo = recent[0];
      foreach (recent[i]) begin
        if (recent[i] > hi) hi = recent[i];
        if (recent[i] < lo) lo = recent[i];
      end
      if (hi - lo > best_gap) best_gap = hi - lo;
    end
    if (fin) begin
      spread_q.push_back(best_gap);
      recent.delete();
      best_gap = 0;
    end
  endtask

  always @(posedge clk) begin
    logic [sws_pkg::SAMPLE_W-1:0] want;
    if (!rst_n) begin
      window_reg = 1;
      recent.delete();
      spread_q.delete();
      best_gap = 0;
      fails = 0;
      seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {sws_pkg::REG_WINDOW_SIZE, 2'b00}) begin
        window_reg = cfg_pwdata[sws_pkg::CFG_W-1:0];
        recent.delete();
        best_gap = 0;
      end
      if (in_push && !in_full) take_sample(in_sample, in_last);
      if (out_pop && !out_empty) begin
        seen++;
        if (spread_q.size() == 0) begin
          fails++;
          $display("%0t: spread %h with none expected", $time, out_spread);
        end else begin
          want = spread_q.pop_front();
          if (out_spread !== want) begin
            fails++;
            $display("%0t: spread expected %h actual %h", $time, want, out_spread);
          end
        end
      end
    end
    fail_count      <= fails;
    spreads_pending <= spread_q.size();
    spreads_seen    <= seen;
  end

endmodule
`default_nettype wire

[tb/sliding_window_max_spread_tb.sv]
// Testbench top: clock, reset, stimulus, register writes and the verdict.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_max_spread_tb;

  localparam int MAX_WINDOW = 1024;
  // a word can pop a whole queue: one S_TAIL/S_CMP round per entry plus the other states
  localparam int SETTLE     = 3000;
  localparam int LIMIT      = 2000000;
  localparam logic [2:0] ADDR_WINDOW = {sws_pkg::REG_WINDOW_SIZE, 2'b00};
  localparam logic [2:0] ADDR_SPARE  = {~sws_pkg::REG_WINDOW_SIZE, 2'b00};

  logic                         clk;
  logic                         rst_n;
  logic                         in_push;
  logic                         in_full;
  logic [sws_pkg::SAMPLE_W-1:0] in_sample;
  logic                         in_last;
  logic                         out_empty;
  logic                         out_pop;
  logic [sws_pkg::SAMPLE_W-1:0] out_spread;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [2:0]                   cfg_paddr;
  logic [31:0]                  cfg_pwdata;
  logic [31:0]                  cfg_prdata;
  logic                         cfg_pready;

  int fail_count;
  int spreads_pending;
  int spreads_seen;
  int send_idle;        // percent of cycles the sender holds back
  int recv_idle;        // percent of cycles the receiver stalls
  int words_sent;
  int windows_used;
  int cycles;
  int unsigned cur_window; // effective window, for sizing sequences

  sliding_window_max_spread #(.MAX_WINDOW(MAX_WINDOW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_sample(in_sample), .in_last(in_last),
    .out_empty(out_empty), .out_pop(out_pop), .out_spread(out_spread),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  sws_spread_checker #(.MAX_WINDOW(MAX_WINDOW)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_sample(in_sample), .in_last(in_last),
    .out_empty(out_empty), .out_pop(out_pop), .out_spread(out_spread),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .spreads_pending(spreads_pending),
    .spreads_seen(spreads_seen)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // receiver: pop decided afresh every cycle out of reset
  always @(posedge clk) begin
    if (rst_n) begin
      out_pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one word; returns after the edge that accepts it
  task automatic put_word(input logic [sws_pkg::SAMPLE_W-1:0] s, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push   <= 1'b1;
    in_sample <= s;
    in_last   <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_sent++;
  endtask

  // block idle: every spread back, then room for a word still in the back end
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    wait (spreads_pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup then access phase; register taken at the access edge
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_WINDOW) begin
      windows_used++;
      cur_window = (data[10:0] == 0) ? 1 :
                   (data[10:0] > MAX_WINDOW) ? MAX_WINDOW : data[10:0];
    end
  endtask

  // mix of full-range, tiny (many ties) and extreme values
  function automatic logic [sws_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      1:       return $urandom_range(7);
      2:       return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) put_word(pick_sample(), i == len - 1);
  endtask

  // random traffic under one idling setting; new window after 40 or more words
  task automatic random_phase(input int n_words);
    int          stop_at;
    int          chunk_end;
    int unsigned w;
    int          len;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      case ($urandom_range(9))
        0:       w = 0;
        1:       w = 1;
        2:       w = $urandom_range(40, 96);
        default: w = $urandom_range(2, 12);
      endcase
      settle();
      reg_write(ADDR_WINDOW, w);
      chunk_end = words_sent + 40;
      while (words_sent < chunk_end && words_sent < stop_at) begin
        // a quarter of sequences are at most one full window long
        if ($urandom_range(3) == 0) len = $urandom_range(1, cur_window);
        else len = $urandom_range(cur_window, 3 * cur_window + 4);
        send_run(len);
      end
    end
  endtask

  initial begin
    in_push     <= 1'b0;
    in_sample   <= '0;
    in_last     <= 1'b0;
    out_pop     <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    send_idle   = 22;
    recv_idle   = 68;
    cur_window  = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of 1 straight out of reset: spread always zero
    put_word(32'hFFFF_FFFF, 1'b0);
    put_word(32'h0, 1'b1);

    // window 3: extremes, then ties, then a lone final word (short sequence)
    settle();
    reg_write(ADDR_WINDOW, 3);
    put_word(32'h0, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b0);
    put_word(32'h5, 1'b0);
    put_word(32'h5, 1'b0);
    put_word(32'h5, 1'b1);
    put_word(32'h1234_5678, 1'b1);

    // hold off until the block has drained
    in_push <= 1'b0;
    @(posedge clk);
    wait (spreads_pending == 0);

    // write to an unused address mid-sequence: must not disturb it
    put_word(32'h10, 1'b0);
    put_word(32'h90, 1'b0);
    settle();
    reg_write(ADDR_SPARE, 32'hFFFF_FFFF);
    put_word(32'h1, 1'b1);

    // window rewrite mid-sequence clears the partial sequence
    put_word(32'h0, 1'b0);
    put_word(32'hFFFF_0000, 1'b0);
    settle();
    reg_write(ADDR_WINDOW, 2);
    put_word(32'h7, 1'b0);
    put_word(32'h3, 1'b1);

    // window zero behaves as one
    settle();
    reg_write(ADDR_WINDOW, 0);
    put_word(32'h0, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b1);

    // oversize value saturating to the largest window
    settle();
    reg_write(ADDR_WINDOW, 32'hFFFF_F7FF);
    send_run(MAX_WINDOW + 2);

    random_phase(120);
    send_idle = 68;
    recv_idle = 22;
    random_phase(120);
    send_idle = 0;
    recv_idle = 0;
    random_phase(120);

    in_push <= 1'b0;
    @(posedge clk);
    wait (spreads_pending == 0);
    repeat (SETTLE) @(posedge clk);

    $display("%0d words sent over %0d window settings, %0d spreads compared",
             words_sent, windows_used, spreads_seen);
    $display("three idling regimes, ties, short runs and full-size windows included");
    if (fail_count == 0 && spreads_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
